[rtl/kda_pkg.sv]
// Package with shared types and constants for the key debounce and auto-repeat block.
`timescale 1ns / 1ps

package kda_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_REPEAT_MASK  = 3'd0,
        REG_DEBOUNCE     = 3'd1,
        REG_FIRST_REPEAT = 3'd2,
        REG_MIN_REPEAT   = 3'd3,
        REG_REPEAT_STEP  = 3'd4
    } t_reg_idx;

    localparam logic [15:0] RST_REPEAT_MASK  = 16'd0;
    localparam logic [7:0]  RST_DEBOUNCE     = 8'd4;
    localparam logic [9:0]  RST_FIRST_REPEAT = 10'd80;
    localparam logic [9:0]  RST_MIN_REPEAT   = 10'd40;
    localparam logic [7:0]  RST_REPEAT_STEP  = 8'd10;

    typedef struct packed {
        logic [15:0] repeat_mask;
        logic [7:0]  debounce_ticks;
        logic [9:0]  first_repeat_ticks;
        logic [9:0]  min_repeat_ticks;
        logic [7:0]  repeat_step;
    } t_cfg;

    typedef struct packed {
        t_func       func;
        logic [15:0] switches;
        logic [15:0] request_mask;
    } t_item;

endpackage

[rtl/kda_cfg_regs.sv]
// APB configuration registers of the key debounce and auto-repeat block.
`timescale 1ns / 1ps

module kda_cfg_regs
    import kda_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_mask        <= RST_REPEAT_MASK;
            r_cfg.debounce_ticks     <= RST_DEBOUNCE;
            r_cfg.first_repeat_ticks <= RST_FIRST_REPEAT;
            r_cfg.min_repeat_ticks   <= RST_MIN_REPEAT;
            r_cfg.repeat_step        <= RST_REPEAT_STEP;
        end else if (w_wr) begin
            case (w_idx)
                REG_REPEAT_MASK:  r_cfg.repeat_mask        <= pwdata[15:0];
                REG_DEBOUNCE:     r_cfg.debounce_ticks     <= pwdata[7:0];
                REG_FIRST_REPEAT: r_cfg.first_repeat_ticks <= pwdata[9:0];
                REG_MIN_REPEAT:   r_cfg.min_repeat_ticks   <= pwdata[9:0];
                REG_REPEAT_STEP:  r_cfg.repeat_step        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_REPEAT_MASK:  prdata = {16'd0, r_cfg.repeat_mask};
            REG_DEBOUNCE:     prdata = {24'd0, r_cfg.debounce_ticks};
            REG_FIRST_REPEAT: prdata = {22'd0, r_cfg.first_repeat_ticks};
            REG_MIN_REPEAT:   prdata = {22'd0, r_cfg.min_repeat_ticks};
            REG_REPEAT_STEP:  prdata = {24'd0, r_cfg.repeat_step};
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/kda_in_stage.sv]
// Input register stage that holds one accepted beat for the core.
`timescale 1ns / 1ps

module kda_in_stage
    import kda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/kda_core.sv]
// Debounce, read flag and repeat timer state with the result register.
`timescale 1ns / 1ps

module kda_core
    import kda_pkg::*;
#(
    parameter int NUM_KEYS   = 16,
    parameter int TIMER_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pressed,
    output logic [15:0] o_stable
);

    localparam int TB = TIMER_BITS;
    localparam int CW = (TB > 8) ? TB : 8;
    localparam logic [15:0] KEY_MASK =
        (NUM_KEYS >= 16) ? 16'hFFFF : 16'((33'd1 << NUM_KEYS) - 33'd1);

    logic [15:0] r_stable_keys, n_stable_keys;
    logic [15:0] r_last_sample, n_last_sample;
    logic [7:0]  r_debounce_count, n_debounce_count;
    logic [15:0] r_read_flags, n_read_flags;
    logic [TB-1:0] r_repeat_timer, n_repeat_timer;
    logic        r_timer_idle, n_timer_idle;
    logic [TB-1:0] r_repeat_interval, n_repeat_interval;
    logic        r_out_valid;
    logic [15:0] r_out_pressed, n_out_pressed;
    logic [15:0] r_out_stable;

    logic          w_take;
    logic [15:0]   w_sw;
    logic [15:0]   w_req;
    logic [TB-1:0] w_first;
    logic [TB-1:0] w_start;
    logic [TB-1:0] w_min;
    logic [TB-1:0] w_timer_dec;
    logic [CW-1:0] w_int_ext;
    logic [CW-1:0] w_step_ext;
    logic [15:0]   w_flags;

    assign o_ready   = !r_out_valid || i_ready;
    assign w_take    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_pressed = r_out_pressed;
    assign o_stable  = r_out_stable;

    assign w_sw        = i_item.switches & KEY_MASK;
    assign w_req       = i_item.request_mask & KEY_MASK;
    assign w_first     = TB'(i_cfg.first_repeat_ticks);
    assign w_start     = (w_first == '0) ? TB'(1) : w_first;
    assign w_min       = TB'(i_cfg.min_repeat_ticks);
    assign w_timer_dec = r_repeat_timer - TB'(1);
    assign w_int_ext   = CW'(r_repeat_interval);
    assign w_step_ext  = CW'(i_cfg.repeat_step);

    always_comb begin
        n_stable_keys     = r_stable_keys;
        n_last_sample     = r_last_sample;
        n_debounce_count  = r_debounce_count;
        n_read_flags      = r_read_flags;
        n_repeat_timer    = r_repeat_timer;
        n_timer_idle      = r_timer_idle;
        n_repeat_interval = r_repeat_interval;
        n_out_pressed     = '0;
        w_flags           = '0;
        if (w_take) begin
            case (i_item.func)
                FUNC_TICK: begin
                    if (w_sw == r_last_sample) begin
                        if (r_debounce_count != '0) begin
                            n_debounce_count = r_debounce_count - 8'd1;
                        end else begin
                            n_stable_keys = w_sw;
                        end
                    end else begin
                        n_debounce_count = i_cfg.debounce_ticks;
                    end
                    n_last_sample = w_sw;
                    w_flags       = r_read_flags & n_stable_keys;
                    n_read_flags  = w_flags;
                    if ((n_stable_keys & i_cfg.repeat_mask & KEY_MASK) != '0) begin
                        if (r_timer_idle) begin
                            n_repeat_timer    = w_start;
                            n_repeat_interval = w_start;
                            n_timer_idle      = 1'b0;
                        end else if (w_timer_dec == '0) begin
                            n_repeat_timer = r_repeat_interval;
                            if (r_repeat_interval > w_min) begin
                                if (w_step_ext >= w_int_ext) begin
                                    n_repeat_interval = TB'(1);
                                end else begin
                                    n_repeat_interval = TB'(w_int_ext - w_step_ext);
                                end
                            end
                            n_read_flags = w_flags & ~i_cfg.repeat_mask & KEY_MASK;
                        end else begin
                            n_repeat_timer = w_timer_dec;
                        end
                    end else begin
                        n_timer_idle = 1'b1;
                    end
                end
                FUNC_QUERY: begin
                    w_flags       = r_read_flags & r_stable_keys;
                    n_out_pressed = w_req & r_stable_keys & ~w_flags;
                    n_read_flags  = w_flags | n_out_pressed;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_keys     <= '0;
            r_last_sample     <= '0;
            r_debounce_count  <= RST_DEBOUNCE;
            r_read_flags      <= '0;
            r_repeat_timer    <= '0;
            r_timer_idle      <= 1'b1;
            r_repeat_interval <= TB'(RST_FIRST_REPEAT);
            r_out_valid       <= 1'b0;
        end else begin
            r_stable_keys     <= n_stable_keys;
            r_last_sample     <= n_last_sample;
            r_debounce_count  <= n_debounce_count;
            r_read_flags      <= n_read_flags;
            r_repeat_timer    <= n_repeat_timer;
            r_timer_idle      <= n_timer_idle;
            r_repeat_interval <= n_repeat_interval;
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_pressed <= n_out_pressed;
            r_out_stable  <= n_stable_keys;
        end
    end

`ifndef SYNTH
    a_timer_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_idle |-> (r_repeat_timer != '0))
        else $error("Repeat timer is zero while running.");

    a_interval_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_timer_idle |-> (r_repeat_interval != '0))
        else $error("Repeat interval is zero while running.");

    a_flags_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_read_flags & ~r_stable_keys) == '0)
        else $error("Read flag set for a released key.");

    a_pressed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_pressed & ~r_out_stable) == '0))
        else $error("Pressed key reported that is not held.");
`endif

endmodule

[rtl/key_debounce_autorepeat.sv]
// Top level of the key debounce and accelerating auto-repeat block.
`timescale 1ns / 1ps

// Each input beat is either a sample tick carrying the raw switch word or a key query,
// and each produces exactly one result beat with the pressed keys and the debounced
// key word. A new beat is accepted every cycle unless the result side holds off. A result
// beat is presented once its input beat has passed through the input register, where the
// key state logic works on it, and then into the result register. Throughput is limited
// only by the result side taking beats. Configuration must be written while no beat is in
// flight.
module key_debounce_autorepeat
    import kda_pkg::*;
#(
    parameter int NUM_KEYS   = 16,
    parameter int TIMER_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] switches, [31:16] request_mask
    input  logic [31:0]           s_axis_tdata,
    // [0] func
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] pressed, [31:16] stable_keys_out
    output logic [31:0]           m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg        w_cfg;
    t_item       w_in_item;
    t_item       w_core_item;
    logic        w_core_valid;
    logic        w_core_ready;
    logic [15:0] w_pressed;
    logic [15:0] w_stable;

    assign w_in_item.func         = t_func'(s_axis_tuser[0]);
    assign w_in_item.switches     = s_axis_tdata[15:0];
    assign w_in_item.request_mask = s_axis_tdata[31:16];
    assign m_axis_tdata           = {w_stable, w_pressed};

    kda_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    kda_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .o_valid (w_core_valid),
        .i_ready (w_core_ready),
        .o_item  (w_core_item)
    );

    kda_core #(
        .NUM_KEYS   (NUM_KEYS),
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (w_core_valid),
        .o_ready   (w_core_ready),
        .i_item    (w_core_item),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pressed (w_pressed),
        .o_stable  (w_stable)
    );

endmodule

[tb/sv/key_debounce_autorepeat_test.sv]
// Testbench for key_debounce_autorepeat: directed and phased random beats checked by a predictor.
`timescale 1ns / 1ps

module key_debounce_autorepeat_test;
    import kda_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int PHASE_BEATS   = 105;
    localparam int N_FIXED       = 6;
    localparam int N_SETUPS      = 8;
    localparam int N_DIRECTED    = 22;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [15:0] pressed;
        logic [15:0] stable;
    } t_result;

    typedef struct packed {
        t_func       f;
        logic [15:0] sw;
        logic [15:0] req;
        logic        typed;
        logic [15:0] pressed;
        logic [15:0] stable;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predicted key state and register copy.
    t_cfg        cfg;
    logic [15:0] key_word;
    logic [15:0] prev_sample;
    logic [7:0]  settle_cnt;
    logic [15:0] read_once;
    logic [9:0]  rpt_timer;
    logic        rpt_idle;
    logic [9:0]  rpt_gap;

    t_result     expected_q[$];
    bit          gaps_on;
    int          mismatches;
    int          beats_in;
    int          beats_out;
    int          expiries;
    int          key_changes;
    int          quiet_cycles;

    t_row directed_rows [N_DIRECTED] = '{
        '{FUNC_QUERY, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'h1234, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_QUERY, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_QUERY, 16'h0000, 16'hAAAA, 1'b1, 16'hAAAA, 16'hFFFF},
        '{FUNC_QUERY, 16'h0000, 16'hFFFF, 1'b1, 16'h5555, 16'hFFFF},
        '{FUNC_QUERY, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'hFFFF},
        '{FUNC_TICK,  16'h8001, 16'h0000, 1'b1, 16'h0000, 16'h8001},
        '{FUNC_QUERY, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 16'h8001},
        '{FUNC_TICK,  16'h7FFE, 16'h5555, 1'b0, 16'h0000, 16'h0000},
        '{FUNC_TICK,  16'h0001, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{FUNC_QUERY, 16'h1234, 16'h5555, 1'b0, 16'h0000, 16'h0000}
    };

    // Zero start interval, interval floor, top extremes, acceleration, no acceleration, no
    // repeat keys.
    t_cfg fixed_setups [N_FIXED] = '{
        '{16'hFFFF, 8'd0,   10'd0,    10'd1,    8'd255},
        '{16'h00F0, 8'd0,   10'd3,    10'd1,    8'd255},
        '{16'h5A5A, 8'd255, 10'd1023, 10'd1023, 8'd0},
        '{16'hA5A5, 8'd2,   10'd12,   10'd2,    8'd3},
        '{16'h0001, 8'd1,   10'd8,    10'd1023, 8'd7},
        '{16'h0000, 8'd3,   10'd5,    10'd1,    8'd1}
    };

    key_debounce_autorepeat u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t ns", what, got, want, $time);
        mismatches++;
    endtask

    function automatic t_result advance_keys(input t_func f, input logic [15:0] sw,
                                             input logic [15:0] req);
        t_result     r;
        logic [9:0]  start;
        logic [15:0] old_word;
        r.pressed = '0;
        old_word = key_word;
        start = (cfg.first_repeat_ticks == '0) ? 10'd1 : cfg.first_repeat_ticks;
        if (f == FUNC_TICK) begin
            if (sw == prev_sample) begin
                if (settle_cnt != '0) begin
                    settle_cnt = settle_cnt - 8'd1;
                end else begin
                    key_word = sw;
                end
            end else begin
                settle_cnt = cfg.debounce_ticks;
            end
            prev_sample = sw;
            read_once &= key_word;
            if ((key_word & cfg.repeat_mask) != '0) begin
                if (rpt_idle) begin
                    rpt_timer = start;
                    rpt_gap = start;
                    rpt_idle = 1'b0;
                end else begin
                    rpt_timer = rpt_timer - 10'd1;
                    if (rpt_timer == '0) begin
                        rpt_timer = rpt_gap;
                        if (rpt_gap > cfg.min_repeat_ticks) begin
                            if (cfg.repeat_step >= rpt_gap) begin
                                rpt_gap = 10'd1;
                            end else begin
                                rpt_gap = rpt_gap - cfg.repeat_step;
                            end
                        end
                        read_once &= ~cfg.repeat_mask;
                        expiries++;
                    end
                end
            end else begin
                rpt_idle = 1'b1;
            end
        end else begin
            read_once &= key_word;
            r.pressed = req & key_word & ~read_once;
            read_once |= r.pressed;
        end
        if (key_word != old_word) begin
            key_changes++;
        end
        r.stable = key_word;
        return r;
    endfunction

    function automatic logic [15:0] pick_pattern();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic apb_access(input logic wr, input t_reg_idx idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic check_reg(input t_reg_idx idx);
        logic [31:0] got;
        logic [31:0] want;
        apb_access(1'b0, idx, '0, got);
        case (idx)
            REG_REPEAT_MASK:  want = 32'(cfg.repeat_mask);
            REG_DEBOUNCE:     want = 32'(cfg.debounce_ticks);
            REG_FIRST_REPEAT: want = 32'(cfg.first_repeat_ticks);
            REG_MIN_REPEAT:   want = 32'(cfg.min_repeat_ticks);
            default:          want = 32'(cfg.repeat_step);
        endcase
        if (got !== want) begin
            report_mismatch($sformatf("register %s readback", idx.name()), got, want);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_REPEAT_MASK:  cfg.repeat_mask = value[15:0];
            REG_DEBOUNCE:     cfg.debounce_ticks = value[7:0];
            REG_FIRST_REPEAT: cfg.first_repeat_ticks = value[9:0];
            REG_MIN_REPEAT:   cfg.min_repeat_ticks = value[9:0];
            default:          cfg.repeat_step = value[7:0];
        endcase
        check_reg(idx);
    endtask

    task automatic send_beat(input t_func f, input logic [15:0] sw, input logic [15:0] req,
                             input bit typed = 1'b0, input t_result want = '0);
        int unsigned gap;
        t_result     pred;
        gap = gaps_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {req, sw};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = advance_keys(f, sw, req);
        expected_q.push_back(typed ? want : pred);
        beats_in++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Each run spans the debounce setting plus at least two beats, capped at 48: ticks of one
    // held switch word mixed with queries and occasional single-bit glitches.
    task automatic run_phase(input int unsigned n_beats);
        int unsigned sent;
        int unsigned hold;
        logic [15:0] held;
        int unsigned roll;
        sent = 0;
        while (sent < n_beats) begin
            held = pick_pattern();
            hold = int'(cfg.debounce_ticks) + 2 + $urandom_range(0, 30);
            if (hold > 48) begin
                hold = 48;
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < hold && sent < n_beats; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 20) begin
                    send_beat(FUNC_QUERY, 16'($urandom), pick_pattern());
                end else if (roll < 25) begin
                    send_beat(FUNC_TICK, held ^ (16'h1 << $urandom_range(0, 15)),
                              16'($urandom));
                end else begin
                    send_beat(FUNC_TICK, held, 16'($urandom));
                end
                sent++;
            end
        end
    endtask

    initial begin : sink
        int unsigned stall;
        forever begin
            stall = gaps_on ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_axis_tdata, '0);
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[15:0] !== want.pressed) begin
                    report_mismatch("pressed", 32'(m_axis_tdata[15:0]), 32'(want.pressed));
                end
                if (m_axis_tdata[31:16] !== want.stable) begin
                    report_mismatch("stable_keys_out", 32'(m_axis_tdata[31:16]),
                                    32'(want.stable));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, expected_q.size());
            $display("key_debounce_autorepeat_test: FAIL");
            $finish;
        end
    end

    initial begin : main
        t_cfg setup;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gaps_on = 1'b1;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        expiries = 0;
        key_changes = 0;
        quiet_cycles = 0;
        cfg = '{RST_REPEAT_MASK, RST_DEBOUNCE, RST_FIRST_REPEAT, RST_MIN_REPEAT,
                RST_REPEAT_STEP};
        key_word = '0;
        prev_sample = '0;
        settle_cnt = RST_DEBOUNCE;
        read_once = '0;
        rpt_timer = '0;
        rpt_idle = 1'b1;
        rpt_gap = RST_FIRST_REPEAT;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i <= int'(REG_REPEAT_STEP); i++) begin
            check_reg(t_reg_idx'(i));
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].f, directed_rows[i].sw, directed_rows[i].req,
                      directed_rows[i].typed,
                      '{directed_rows[i].pressed, directed_rows[i].stable});
        end

        for (int p = 0; p < N_SETUPS; p++) begin
            settle();
            if (p < N_FIXED) begin
                setup = fixed_setups[p];
            end else begin
                setup = '{16'($urandom), 8'($urandom_range(0, 5)),
                          10'($urandom_range(1, 24)), 10'($urandom_range(1, 10)),
                          8'($urandom_range(0, 6))};
            end
            // Upper bits beyond each register's width carry junk that must be dropped.
            write_reg(REG_REPEAT_MASK, {16'($urandom), setup.repeat_mask});
            write_reg(REG_DEBOUNCE, {24'($urandom), setup.debounce_ticks});
            write_reg(REG_FIRST_REPEAT, {22'($urandom), setup.first_repeat_ticks});
            write_reg(REG_MIN_REPEAT, {22'($urandom), setup.min_repeat_ticks});
            write_reg(REG_REPEAT_STEP, {24'($urandom), setup.repeat_step});
            @(negedge i_clk);
            psel <= 1'b0;
            penable <= 1'b0;
            run_phase(PHASE_BEATS);
        end

        settle();
        $display("Sent %0d input beats and checked %0d result beats over %0d register setups.",
                 beats_in, beats_out, N_SETUPS + 1);
        $display("Debounced key word changed %0d times; repeat timer expired %0d times.",
                 key_changes, expiries);
        if (mismatches == 0) begin
            $display("key_debounce_autorepeat_test: PASS");
        end else begin
            $display("key_debounce_autorepeat_test: FAIL");
        end
        $finish;
    end

endmodule
